FILE: design/wildcard_byte_pattern_scanner_assert.svh
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WBPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/wbps_pkg.sv
`default_nettype none

package wbps_pkg;

    localparam int ADDR_W    = 48;
    localparam int LEN_W     = 6;
    localparam int PAT_BYTES = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_0_7   = 3'd0,
        CFG_PAT_8_15  = 3'd1,
        CFG_PAT_16_23 = 3'd2,
        CFG_PAT_24_31 = 3'd3,
        CFG_WILDCARD  = 3'd4,
        CFG_LENGTH    = 3'd5,
        CFG_BASE      = 3'd6
    } cfg_reg_t;

    typedef logic [PAT_BYTES-1:0][7:0] pat_t;

endpackage

`default_nettype wire

FILE: design/wildcard_byte_pattern_scanner.sv
`default_nettype none
// Channel   Signals                                          Direction
// s_        s_valid s_ready s_image_byte s_last_byte         in  (one image byte per beat)
// m_        m_valid m_ready m_found m_match_address          out (at most one per beat)
// cfg_      cfg_valid cfg_ready cfg_index cfg_data           in  (register writes)
//
// One byte beat per cycle while s_ready is high; its result is registered on accept in the
// output register (or skid). Window compare, offset check and address add sit before that
// register; the aligned pattern is rebuilt from the register write data in the write cycle.
// A two-entry output (register plus skid) keeps s_ready high while one result waits;
// s_ready drops only when both are full.
// aresetn is synchronous, active low; it clears all but the output and skid data registers.

module wildcard_byte_pattern_scanner #(
    parameter int MAX_PATTERN = 32,
    parameter int OFFSET_BITS = 32
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [7:0]                       s_image_byte,
    input  wire                              s_last_byte,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic                             m_found,
    output logic [wbps_pkg::ADDR_W-1:0]      m_match_address,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [wbps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wbps_pkg::*;

    // configuration
    pat_t                     pat_reg, pat_next;
    logic [PAT_BYTES-1:0]     mask_reg, mask_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [ADDR_W-1:0]        base_reg, base_next;

    // pattern aligned to window slots, entry 0 newest
    logic [MAX_PATTERN-1:0][7:0] exp_reg, exp_next;
    logic [MAX_PATTERN-1:0]      care_reg, care_next;
    logic                        armed_reg, armed_next;
    logic [LEN_W-1:0]            slot_idx [MAX_PATTERN];

    // search state
    logic [MAX_PATTERN-1:0][7:0] win_reg, win_shift;
    logic [OFFSET_BITS-1:0]      off_reg;
    logic                        found_reg;

    // output register and skid
    logic                        m_valid_reg, m_found_reg;
    logic [ADDR_W-1:0]           m_addr_reg;
    logic                        skid_valid_reg, skid_found_reg;
    logic [ADDR_W-1:0]           skid_addr_reg;

    logic                        s_accept, m_pop;
    logic [MAX_PATTERN-1:0]      slot_hit;
    logic [OFFSET_BITS:0]        t_plus1;
    logic                        len_ok, match;
    logic [OFFSET_BITS-1:0]      start_off;
    logic [ADDR_W-1:0]           hit_addr;
    logic                        res_valid, res_found;
    logic [ADDR_W-1:0]           res_addr;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign s_accept  = s_valid && s_ready;
    assign m_pop     = m_valid_reg && m_ready;

    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_match_address = m_addr_reg;

    always_comb begin
        pat_next  = pat_reg;
        mask_next = mask_reg;
        len_next  = len_reg;
        base_next = base_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PAT_0_7:   pat_next[7:0]   = cfg_data;
                CFG_PAT_8_15:  pat_next[15:8]  = cfg_data;
                CFG_PAT_16_23: pat_next[23:16] = cfg_data;
                CFG_PAT_24_31: pat_next[31:24] = cfg_data;
                CFG_WILDCARD:  mask_next = cfg_data[PAT_BYTES-1:0];
                CFG_LENGTH:    len_next  = cfg_data[LEN_W-1:0];
                CFG_BASE:      base_next = cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // slot j of the window faces pattern byte len-1-j
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            slot_idx[j]  = len_next - LEN_W'(j) - LEN_W'(1);
            exp_next[j]  = pat_next[slot_idx[j][LEN_W-2:0]];
            care_next[j] = (LEN_W'(j) < len_next) && !mask_next[slot_idx[j][LEN_W-2:0]];
        end
        armed_next = (len_next != '0) && (len_next <= LEN_W'(MAX_PATTERN))
                     && (base_next != '0);
    end

    always_comb begin
        win_shift[0] = s_image_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            win_shift[j] = win_reg[j-1];
        end
        for (int j = 0; j < MAX_PATTERN; j++) begin
            slot_hit[j] = !care_reg[j] || (win_shift[j] == exp_reg[j]);
        end
    end

    assign t_plus1   = {1'b0, off_reg} + (OFFSET_BITS+1)'(1);
    assign len_ok    = t_plus1 >= (OFFSET_BITS+1)'(len_reg);
    assign start_off = OFFSET_BITS'(t_plus1 - (OFFSET_BITS+1)'(len_reg));
    assign hit_addr  = base_reg + ADDR_W'(start_off);
    assign match     = !found_reg && armed_reg && len_ok && (&slot_hit);
    assign res_valid = match || (s_last_byte && !found_reg);
    assign res_found = match;
    assign res_addr  = match ? hit_addr : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg        <= '0;
            mask_reg       <= '0;
            len_reg        <= '0;
            base_reg       <= '0;
            exp_reg        <= '0;
            care_reg       <= '0;
            armed_reg      <= 1'b0;
            win_reg        <= '0;
            off_reg        <= '0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            pat_reg   <= pat_next;
            mask_reg  <= mask_next;
            len_reg   <= len_next;
            base_reg  <= base_next;
            exp_reg   <= exp_next;
            care_reg  <= care_next;
            armed_reg <= armed_next;

            if (s_accept) begin
                if (s_last_byte) begin
                    win_reg   <= '0;
                    off_reg   <= '0;
                    found_reg <= 1'b0;
                end else begin
                    win_reg   <= win_shift;
                    found_reg <= found_reg || match;
                    if (off_reg != '1) begin
                        off_reg <= off_reg + OFFSET_BITS'(1);
                    end
                end
            end

            // skid full implies no accept this cycle
            if (skid_valid_reg) begin
                if (m_pop) begin
                    m_found_reg    <= skid_found_reg;
                    m_addr_reg     <= skid_addr_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (s_accept && res_valid) begin
                if (!m_valid_reg || m_pop) begin
                    m_valid_reg <= 1'b1;
                    m_found_reg <= res_found;
                    m_addr_reg  <= res_addr;
                end else begin
                    skid_valid_reg <= 1'b1;
                    skid_found_reg <= res_found;
                    skid_addr_reg  <= res_addr;
                end
            end else if (m_pop) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`include "wildcard_byte_pattern_scanner_assert.svh"

    `WBPS_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, m_valid_reg, "skid full with output empty")
    `WBPS_ASSERT_NOW(a_miss_addr_zero, m_valid_reg && !m_found_reg, m_addr_reg == '0, "not-found beat carries an address")
    `WBPS_ASSERT_NEXT(a_last_clears, s_accept && s_last_byte, (off_reg == '0) && !found_reg && (win_reg == '0), "search state not cleared after last byte")
    `WBPS_ASSERT_NEXT(a_hit_sets_found, s_accept && match && !s_last_byte, found_reg, "match did not set found flag")
    `WBPS_ASSERT_NOW(a_one_hit_per_scan, found_reg, !match, "second match in one scan")

endmodule

`default_nettype wire

FILE: tb/sv/wildcard_byte_pattern_scanner_test.sv
module wildcard_byte_pattern_scanner_test;
    import wbps_pkg::*;

    localparam int OFFSET_BITS  = 32;
    localparam int MAX_PAT      = 32;
    localparam int ITEM_TARGET  = 1850;
    localparam int PHASE_BYTES  = 150;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } image_beat_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } scan_result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    wire                   s_ready;
    logic [7:0]            s_image_byte = 8'h00;
    logic                  s_last_byte = 1'b0;
    wire                   m_valid;
    logic                  m_ready = 1'b0;
    wire                   m_found;
    wire  [ADDR_W-1:0]     m_match_address;
    logic                  cfg_valid = 1'b0;
    wire                   cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    wildcard_byte_pattern_scanner dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_image_byte    (s_image_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_match_address (m_match_address),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 aclk = ~aclk;

    // scanner copy: registers and search state
    pat_t                   pat_cfg = '0;
    logic [31:0]            wild_cfg = '0;
    logic [LEN_W-1:0]       len_cfg = '0;
    logic [ADDR_W-1:0]      base_cfg = '0;
    logic [7:0]             window [MAX_PAT] = '{default: 8'h00};
    logic [OFFSET_BITS-1:0] next_offset = '0;
    logic                   match_reported = 1'b0;

    image_beat_t  pending_beats [$];
    reg_write_t   pending_writes [$];
    scan_result_t expected_results [$];

    image_beat_t  sent_beat;
    reg_write_t   next_write;
    scan_result_t predicted;
    scan_result_t want;
    int           send_gap = 0;
    int           stall_left = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           beats_queued = 0;
    int           fail_count = 0;
    int           quiet_cycles = 0;

    // window[0] is the newest byte; pattern byte k faces window[len-1-k]
    function automatic logic window_hit(input int len);
        for (int k = 0; k < len; k++)
            if (!wild_cfg[k] && window[len-1-k] !== pat_cfg[k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit scan_step(input image_beat_t beat, output scan_result_t res);
        logic [63:0] t;
        bit          hit;
        t   = 64'(next_offset);
        hit = 1'b0;
        res = '0;
        for (int i = MAX_PAT - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = beat.data;
        if (!match_reported && len_cfg != 0 && len_cfg <= MAX_PAT && base_cfg != 0 &&
            t + 1 >= 64'(len_cfg) && window_hit(int'(len_cfg))) begin
            res.found      = 1'b1;
            res.addr       = base_cfg + ADDR_W'(t + 1 - 64'(len_cfg));
            match_reported = 1'b1;
            hit            = 1'b1;
        end
        if (next_offset != '1)
            next_offset++;
        if (beat.last) begin
            if (!hit && !match_reported) begin
                res = '0;
                hit = 1'b1;
            end
            window         = '{default: 8'h00};
            next_offset    = '0;
            match_reported = 1'b0;
        end
        return hit;
    endfunction

    // image byte driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (scan_step(sent_beat, predicted))
                    expected_results.insert(expected_results.size(), predicted);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0 && send_idle_pct > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    sent_beat = pending_beats.pop_front();
                    s_valid      <= 1'b1;
                    s_image_byte <= sent_beat.data;
                    s_last_byte  <= sent_beat.last;
                    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
                        send_gap = $urandom_range(19, 1);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // register write driver; the copy updates on the same beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PAT_0_7:   pat_cfg[7:0]   = cfg_data;
                    CFG_PAT_8_15:  pat_cfg[15:8]  = cfg_data;
                    CFG_PAT_16_23: pat_cfg[23:16] = cfg_data;
                    CFG_PAT_24_31: pat_cfg[31:24] = cfg_data;
                    CFG_WILDCARD:  wild_cfg = cfg_data[31:0];
                    CFG_LENGTH:    len_cfg  = cfg_data[LEN_W-1:0];
                    CFG_BASE:      base_cfg = cfg_data[ADDR_W-1:0];
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready) begin
                if (pending_writes.size() > 0) begin
                    next_write = pending_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= next_write.index;
                    cfg_data  <= next_write.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: found %0b match_address %h",
                           m_found, m_match_address);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_found !== want.found) begin
                        $error("found: expected %0b, actual %0b", want.found, m_found);
                        fail_count++;
                    end
                    if (m_match_address !== want.addr) begin
                        $error("match_address: expected %h, actual %h",
                               want.addr, m_match_address);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0 && recv_idle_pct > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct) begin
                stall_left = $urandom_range(18, 0);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("wildcard_byte_pattern_scanner_test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic queue_write(input logic [CFG_IDX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] data);
        pending_writes.insert(pending_writes.size(), reg_write_t'{index, data});
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic last);
        pending_beats.insert(pending_beats.size(), image_beat_t'{data, last});
        beats_queued++;
    endtask

    // wait out every beat, write and result, then the pipeline tail
    task automatic settle();
        @(negedge aclk);
        while (pending_beats.size() > 0 || s_valid || pending_writes.size() > 0 ||
               cfg_valid || expected_results.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        pat_t        plan_pat;
        logic [31:0] plan_wild;
        logic [47:0] plan_base;
        logic [63:0] data;
        logic [7:0]  b;
        int          plan_len;
        int          img_len;
        int          pos;
        int          phase_bytes;
        int          pick;
        bit          embed;
        bit          mutate;
        bit          final_part;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // registers still at reset: empty pattern and zero base
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        settle();

        // DE AD ?? EF, base near the top so the first hit wraps to zero
        queue_write(CFG_PAT_0_7,   64'h0123_4567_EF5A_ADDE);
        queue_write(CFG_PAT_8_15,  {$urandom, $urandom});
        queue_write(CFG_PAT_16_23, {$urandom, $urandom});
        queue_write(CFG_PAT_24_31, {$urandom, $urandom});
        queue_write(CFG_WILDCARD,  64'hFFFF_FFFF_0000_0004);
        queue_write(CFG_LENGTH,    64'hFFFF_FFFF_FFFF_FFC4);
        queue_write(CFG_BASE,      64'hABCD_FFFF_FFFF_FFFE);
        settle();
        queue_byte(8'h11, 1'b0);
        queue_byte(8'h22, 1'b0);
        queue_byte(8'hDE, 1'b0);
        queue_byte(8'hAD, 1'b0);
        queue_byte(8'h77, 1'b0);
        queue_byte(8'hEF, 1'b0);
        // second copy after the hit stays silent, last byte too
        queue_byte(8'hDE, 1'b0);
        queue_byte(8'hAD, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hEF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        // hit on the last byte
        queue_byte(8'hDE, 1'b0);
        queue_byte(8'hAD, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hEF, 1'b1);
        // image shorter than the pattern
        queue_byte(8'hDE, 1'b0);
        queue_byte(8'hAD, 1'b1);
        settle();

        queue_write(CFG_BASE, 64'h0);
        settle();
        queue_byte(8'hDE, 1'b0);
        queue_byte(8'hAD, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hEF, 1'b1);
        settle();

        // length 33 after masking, plus a write to an unmapped index
        queue_write(CFG_LENGTH, 64'hFFFF_FFFF_FFFF_FFE1);
        queue_write(CFG_BASE,   64'h1);
        queue_write(CFG_NO_REG, 64'hFFFF_FFFF_FFFF_FFFF);
        settle();
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        settle();

        while (beats_queued < ITEM_TARGET) begin
            final_part = beats_queued >= ITEM_TARGET - 200;
            pick = $urandom_range(2);
            send_idle_pct = final_part ? 0 : (pick == 0 ? 0 : (pick == 1 ? 5 : 25));
            pick = $urandom_range(2);
            recv_idle_pct = final_part ? 0 : (pick == 0 ? 0 : (pick == 1 ? 3 : 15));

            for (int w = 0; w < 4; w++) begin
                data = {$urandom, $urandom};
                plan_pat[8*w +: 8] = data;
                queue_write(cfg_reg_t'(CFG_PAT_0_7 + w), data);
            end
            pick = $urandom_range(5);
            case (pick)
                0:       plan_wild = '0;
                1:       plan_wild = '1;
                2:       plan_wild = $urandom & $urandom;
                default: plan_wild = $urandom;
            endcase
            queue_write(CFG_WILDCARD, {$urandom, plan_wild});
            pick = $urandom_range(11);
            case (pick)
                0:       plan_len = 0;
                1:       plan_len = 32;
                2:       plan_len = $urandom_range(63, 33);
                3:       plan_len = 1;
                4:       plan_len = $urandom_range(31, 9);
                default: plan_len = $urandom_range(8, 2);
            endcase
            data = {$urandom, $urandom};
            data[LEN_W-1:0] = plan_len[LEN_W-1:0];
            queue_write(CFG_LENGTH, data);
            pick = $urandom_range(9);
            case (pick)
                0:       plan_base = '0;
                1:       plan_base = {16'hFFFF, 24'hFFFFFF, 8'($urandom)};
                default: plan_base = {16'($urandom), 32'($urandom)};
            endcase
            queue_write(CFG_BASE, {16'($urandom), plan_base});
            if ($urandom_range(3) == 0)
                queue_write(CFG_NO_REG, {$urandom, $urandom});
            settle();

            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                if ($urandom_range(9) == 0)
                    img_len = $urandom_range(120, 40);
                else
                    img_len = $urandom_range((plan_len > 32 ? 32 : plan_len) + 12, 1);
                embed = plan_len >= 1 && plan_len <= 32 && img_len >= plan_len &&
                        $urandom_range(9) < 7;
                pos = embed ? $urandom_range(img_len - plan_len, 0) : 0;
                // near miss: one byte of the copy flipped
                mutate = embed && $urandom_range(4) == 0;
                pick = mutate ? $urandom_range(plan_len - 1, 0) : 0;
                for (int i = 0; i < img_len; i++) begin
                    b = 8'($urandom);
                    if (embed && i >= pos && i < pos + plan_len) begin
                        if (!plan_wild[i-pos])
                            b = plan_pat[i-pos];
                        if (mutate && i - pos == pick)
                            b = b ^ (8'h01 << $urandom_range(7));
                    end
                    // occasionally leave the scan open into the next phase
                    queue_byte(b, i == img_len - 1 &&
                               !(phase_bytes + img_len >= PHASE_BYTES && !final_part &&
                                 $urandom_range(7) == 0));
                end
                phase_bytes += img_len;
            end
            settle();
        end

        settle();
        if (fail_count == 0)
            $display("wildcard_byte_pattern_scanner_test passed");
        else
            $display("wildcard_byte_pattern_scanner_test failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/wbps_pkg.sv
design/wildcard_byte_pattern_scanner.sv
tb/sv/wildcard_byte_pattern_scanner_test.sv
